FILE: hdl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants of the disk request scheduler
// policy codes, request record, controller/datapath command and status
// ----------------------------------------------------------------------------
`default_nettype none
package drs_pkg;

  localparam int unsigned DefQueueDepth = 16;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SSTF = 2'd1,
    POL_LOOK = 2'd2,
    POL_RSVD = 2'd3
  } policy_e;

  typedef enum logic {
    REQ_ARRIVE   = 1'b0,
    REQ_COMPLETE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arrival;
    logic [15:0] cylinder;
    logic [31:0] address;
    logic [15:0] process;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  // controller to datapath
  typedef struct packed {
    logic load_in;    // capture the input item
    logic arrive;     // perform arrival update
    logic scan_start; // clear the running best
    logic scan_step;  // evaluate one entry
    logic take;       // move chosen entry into service
    logic empty_done; // completion on empty queue
    logic shift_step; // move one entry down
    logic finish;     // shrink count
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_complete;
    logic queue_empty;
    logic scan_last;
    logic shift_last;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: hdl/drs_if.sv
// ----------------------------------------------------------------------------
// drs_in_if / drs_out_if: valid/ready channels of the scheduler
// source drives valid and payload, sink drives ready
// ----------------------------------------------------------------------------
`default_nettype none
interface drs_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] req_id;
  logic [31:0] req_arrival;
  logic [15:0] req_cylinder;
  logic [31:0] req_address;
  logic [15:0] req_process;
  logic [31:0] now_time;
  logic [15:0] head_cylinder;
  logic        scan_up;
  modport source (output valid, req_type, req_id, req_arrival, req_cylinder,
                  req_address, req_process, now_time, head_cylinder, scan_up,
                  input ready);
  modport sink (input valid, req_type, req_id, req_arrival, req_cylinder,
                req_address, req_process, now_time, head_cylinder, scan_up,
                output ready);
endinterface

interface drs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_id;
  logic [31:0] out_arrival;
  logic [15:0] out_cylinder;
  logic [31:0] out_address;
  logic [15:0] out_process;
  logic        dropped;
  logic [4:0]  queue_level;
  modport source (output valid, out_id, out_arrival, out_cylinder, out_address,
                  out_process, dropped, queue_level, input ready);
  modport sink (input valid, out_id, out_arrival, out_cylinder, out_address,
                out_process, dropped, queue_level, output ready);
endinterface
`default_nettype wire

FILE: hdl/drs_ram.sv
// ----------------------------------------------------------------------------
// drs_ram: generic single-write, single-read ram
// one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none
module drs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hdl/drs_datapath.sv
// ----------------------------------------------------------------------------
// drs_datapath: queue memory, request in service and selection scan
// scans one entry a cycle to pick the best, then shifts the tail down
// ----------------------------------------------------------------------------
`default_nettype none
module drs_datapath
  import drs_pkg::*;
#(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic [1:0] policy_i,
  input  wire logic  req_type_i,
  input  wire rec_t  req_i,
  input  wire logic [31:0] now_time_i,
  input  wire logic [15:0] head_i,
  input  wire logic  scan_up_i,
  input  wire dp_cmd_t cmd_i,
  output dp_sts_t    sts_o,
  output rec_t       serv_o,
  output logic       dropped_o,
  output logic [4:0] level_o
);
  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  // look classes, lower is preferred
  localparam logic [1:0] ClsSame    = 2'd0;
  localparam logic [1:0] ClsAlong   = 2'd1;
  localparam logic [1:0] ClsAgainst = 2'd2;

  logic [CntW-1:0] count_q, count_d;
  rec_t serv_q, serv_d;
  logic dropped_q, dropped_d;
  rec_t in_rec_q;
  logic type_q, up_q;
  logic [31:0] now_q;
  logic [15:0] head_q;
  logic [1:0] pol_q;

  // scan state: the read address is registered through the ram, so it leads the data on rdata
  logic [CntW-1:0] idx_q, idx_d;        // entry index of data now on rdata
  logic [AddrW-1:0] best_q, best_d;
  logic [31:0] best_arr_q, best_arr_d;
  logic [15:0] best_dist_q, best_dist_d;
  logic [1:0]  best_cls_q, best_cls_d;
  logic        have_q, have_d;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  rec_t wdata, rdata;

  drs_ram #(.Width(RecW), .Depth(QueueDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // candidate metrics
  logic [15:0] cand_dist;
  logic [1:0]  cls;
  logic        better;
  always_comb begin
    cand_dist = (rdata.cylinder > head_q) ? rdata.cylinder - head_q
                                          : head_q - rdata.cylinder;
    if (rdata.cylinder == head_q) begin
      cls = ClsSame;
    end else if (up_q ? (rdata.cylinder > head_q) : (rdata.cylinder < head_q)) begin
      cls = ClsAlong;
    end else begin
      cls = ClsAgainst;
    end
    better = 1'b0;
    case (pol_q)
      POL_FCFS: better = rdata.arrival < best_arr_q;
      POL_SSTF: better = (cand_dist < best_dist_q) ||
                         (cand_dist == best_dist_q && rdata.arrival < best_arr_q);
      default: begin
        if (cls < best_cls_q) begin
          better = 1'b1;
        end else if (cls == best_cls_q) begin
          if (cls == ClsSame) better = rdata.arrival < best_arr_q;
          else                better = cand_dist < best_dist_q;
        end
      end
    endcase
    if (!have_q) better = 1'b1;
  end

  logic serv_zero;
  assign serv_zero = (serv_q == '0);

  always_comb begin
    count_d     = count_q;
    serv_d      = serv_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    best_d      = best_q;
    best_arr_d  = best_arr_q;
    best_dist_d = best_dist_q;
    best_cls_d  = best_cls_q;
    have_d      = have_q;
    we          = 1'b0;
    waddr       = count_q[AddrW-1:0];
    wdata       = in_rec_q;
    raddr       = '0;
    if (cmd_i.arrive) begin
      dropped_d = 1'b0;
      if (serv_zero) begin
        serv_d = in_rec_q;
      end else if (count_q < CntW'(QueueDepth)) begin
        if (pol_q == POL_FCFS) wdata.arrival = now_q;
        we      = 1'b1;
        count_d = count_q + 1'b1;
      end else begin
        dropped_d = 1'b1;
      end
    end
    if (cmd_i.empty_done) begin
      serv_d    = '0;
      dropped_d = 1'b0;
    end
    if (cmd_i.scan_start) begin
      // read of entry 0 issued now
      raddr  = '0;
      idx_d  = '0;
      have_d = 1'b0;
      dropped_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (better) begin
        best_d      = idx_q[AddrW-1:0];
        best_arr_d  = rdata.arrival;
        best_dist_d = cand_dist;
        best_cls_d  = cls;
        have_d      = 1'b1;
      end
      idx_d = idx_q + 1'b1;
      raddr = (idx_q + 1'b1 < count_q) ? AddrW'(idx_q + 1'b1) : (better ? idx_q[AddrW-1:0] : best_q);
    end
    if (cmd_i.take) begin
      // rdata holds the chosen entry
      serv_d = rdata;
      idx_d  = CntW'(best_q);
      raddr  = AddrW'(CntW'(best_q) + 1'b1);
    end
    if (cmd_i.shift_step) begin
      we    = 1'b1;
      waddr = idx_q[AddrW-1:0];
      wdata = rdata;
      idx_d = idx_q + 1'b1;
      raddr = AddrW'(idx_q + 2'd2);
    end
    if (cmd_i.finish) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      serv_q    <= '0;
      dropped_q <= 1'b0;
      idx_q     <= '0;
      have_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      serv_q    <= serv_d;
      dropped_q <= dropped_d;
      idx_q     <= idx_d;
      have_q    <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_arr_q  <= best_arr_d;
    best_dist_q <= best_dist_d;
    best_cls_q  <= best_cls_d;
    if (cmd_i.load_in) begin
      in_rec_q <= req_i;
      type_q   <= req_type_i;
      up_q     <= scan_up_i;
      now_q    <= now_time_i;
      head_q   <= head_i;
      pol_q    <= policy_i;
    end
  end

  assign sts_o.is_complete = type_q;
  assign sts_o.queue_empty = (count_q == '0);
  assign sts_o.scan_last   = (idx_q + 1'b1 >= count_q);
  // gap closed once the entry at idx has no successor
  assign sts_o.shift_last  = (idx_q + 1'b1 >= count_q);
  assign serv_o    = serv_q;
  assign dropped_o = dropped_q;
  assign level_o   = 5'(count_q);
endmodule
`default_nettype wire

FILE: hdl/drs_ctrl.sv
// ----------------------------------------------------------------------------
// drs_ctrl: scheduler sequencer
// steps an item through load and dispatch, and a completion on a non-empty
// queue also through scan, take and shift, then offers the result
`default_nettype none
module drs_ctrl
  import drs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DISP  = 7'b0000010,
    ST_SCAN0 = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_TAKE  = 7'b0010000,
    ST_SHIFT = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        if (!sts_i.is_complete) begin
          cmd_o.arrive = 1'b1;
          state_d = ST_DONE;
        end else if (sts_i.queue_empty) begin
          cmd_o.empty_done = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN0: state_d = ST_SCAN;
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = ST_TAKE;
      end
      ST_TAKE: begin
        cmd_o.take = 1'b1;
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts_i.shift_last) begin
          cmd_o.finish = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

FILE: hdl/disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// disk_request_scheduler: fcfs / sstf / look disk request scheduler
// keeps one request in service and a queue, answers each item with one result
// ----------------------------------------------------------------------------
// Each accepted item produces exactly one result showing the request in
// service afterwards, the drop flag and the queue level. A completion on a
// non-empty queue of n entries scans the queue memory one entry a cycle
// through its registered read port, then closes the gap one entry a cycle.
// One item is in work at a time; the result register lets the next item in
// once the result is taken or in the cycle it is taken. The policy register
// is to be written by cfg_we_i only while idle; the block itself does not
// enforce it. Code 3 acts as look.
`default_nettype none
module disk_request_scheduler
  import drs_pkg::*;
#(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  drs_in_if.sink          req_i,
  drs_out_if.source       rsp_o
);
  logic [1:0] policy_q;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  rec_t       in_rec, serv;

  // policy register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FCFS;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  assign in_rec.id       = req_i.req_id;
  assign in_rec.arrival  = req_i.req_arrival;
  assign in_rec.cylinder = req_i.req_cylinder;
  assign in_rec.address  = req_i.req_address;
  assign in_rec.process  = req_i.req_process;

  // sequencer
  drs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // queue, service register and selection scan
  drs_datapath #(.QueueDepth(QueueDepth)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .policy_i  (policy_q),
    .req_type_i(req_i.req_type),
    .req_i     (in_rec),
    .now_time_i(req_i.now_time),
    .head_i    (req_i.head_cylinder),
    .scan_up_i (req_i.scan_up),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .serv_o    (serv),
    .dropped_o (rsp_o.dropped),
    .level_o   (rsp_o.queue_level)
  );

  assign rsp_o.out_id       = serv.id;
  assign rsp_o.out_arrival  = serv.arrival;
  assign rsp_o.out_cylinder = serv.cylinder;
  assign rsp_o.out_address  = serv.address;
  assign rsp_o.out_process  = serv.process;
endmodule
`default_nettype wire

FILE: hdl/drs_checker.sv
// ----------------------------------------------------------------------------
// drs_checker: port-level checks of the disk request scheduler
// watches handshakes and result fields over time
// ----------------------------------------------------------------------------
`default_nettype none
module drs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       dropped_i,
  input wire logic [4:0] queue_level_i
);
  // held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(queue_level_i))
    else $error("result changed while stalled");

  // no new request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken over pending result");

  // a dropped request never shows an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dropped_i |-> queue_level_i != 5'd0)
    else $error("drop with room in queue");

  // an accepted request yields no result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i)
    else $error("result too early");
endmodule

bind disk_request_scheduler drs_checker u_drs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .dropped_i    (rsp_o.dropped),
  .queue_level_i(rsp_o.queue_level)
);
`default_nettype wire
